[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the vacuum pump channel checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

[sv/vpcc_pkg.sv]
// ----------------------------------------------------------------------------
// Vacuum pump channel control package
// Types, codes and constants shared by the channel control modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vpcc_pkg;

    // Field widths fixed by the channel interface.
    localparam int SAMPLE_W    = 12;
    localparam int STEP_CODE_W = 5;

    // Default parameter values.
    localparam int SAMPLE_BITS_DEFAULT   = 12;
    localparam int RELEASE_LIMIT_DEFAULT = 20;

    // Commanded modes.
    typedef enum logic [1:0] {
        MODE_DISABLED = 2'd0,
        MODE_OFF      = 2'd1,
        MODE_ON       = 2'd2,
        MODE_FORCED   = 2'd3
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_PRESENCE_THRESHOLD = 2'd0,
        CFG_VACUUM_GOOD_LEVEL  = 2'd1,
        CFG_VACUUM_BAD_LEVEL   = 2'd2,
        CFG_SUCTION_ON_RELEASE = 2'd3
    } cfg_index_t;

    // Release sequence step marks.
    localparam logic [STEP_CODE_W-1:0] SUCTION_PUMP_START_STEP  = 5'd0;
    localparam logic [STEP_CODE_W-1:0] SUCTION_VALVE_OPEN_STEP  = 5'd2;
    localparam logic [STEP_CODE_W-1:0] SUCTION_PUMP_STOP_STEP   = 5'd3;
    localparam logic [STEP_CODE_W-1:0] SUCTION_VALVE_CLOSE_STEP = 5'd5;
    localparam logic [STEP_CODE_W-1:0] PLAIN_VALVE_OPEN_STEP    = 5'd0;
    localparam logic [STEP_CODE_W-1:0] PLAIN_VALVE_CLOSE_STEP   = 5'd19;

    // One control tick.
    typedef struct packed {
        logic [1:0]          pump_mode;
        logic                sensor_pin;
        logic [SAMPLE_W-1:0] vacuum_sample;
    } in_item_t;

    // One set of driven lines and status flags.
    typedef struct packed {
        logic standby_release;
        logic pump_drive;
        logic valve_open;
        logic part_present;
        logic sensor_active;
    } out_item_t;

    // Configuration register contents.
    typedef struct packed {
        logic [SAMPLE_W-1:0] presence_threshold;
        logic [SAMPLE_W-1:0] vacuum_good_level;
        logic [SAMPLE_W-1:0] vacuum_bad_level;
        logic                suction_on_release;
    } cfg_t;

endpackage

[sv/vpcc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the thresholds and release option written through the write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vpcc_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [vpcc_pkg::SAMPLE_W-1:0] cfg_wdata,
    output vpcc_pkg::cfg_t                cfg
);

    vpcc_pkg::cfg_t cfg_reg;
    vpcc_pkg::cfg_t cfg_next;

    // Decode the write into the addressed register.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (vpcc_pkg::cfg_index_t'(cfg_index))
                vpcc_pkg::CFG_PRESENCE_THRESHOLD: cfg_next.presence_threshold = cfg_wdata;
                vpcc_pkg::CFG_VACUUM_GOOD_LEVEL:  cfg_next.vacuum_good_level  = cfg_wdata;
                vpcc_pkg::CFG_VACUUM_BAD_LEVEL:   cfg_next.vacuum_bad_level   = cfg_wdata;
                vpcc_pkg::CFG_SUCTION_ON_RELEASE: cfg_next.suction_on_release = cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/vpcc_channel_logic.sv]
// ----------------------------------------------------------------------------
// Channel control logic
// Per-tick mode tracking, pump hysteresis and timed release sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vpcc_channel_logic #(
    parameter int SAMPLE_BITS   = vpcc_pkg::SAMPLE_BITS_DEFAULT,
    parameter int RELEASE_LIMIT = vpcc_pkg::RELEASE_LIMIT_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  vpcc_pkg::in_item_t  item,
    input  vpcc_pkg::cfg_t      cfg,
    output vpcc_pkg::out_item_t result
);

    // Compare width: the sample field never carries more than SAMPLE_W bits.
    localparam int CMP_BITS  = (SAMPLE_BITS < vpcc_pkg::SAMPLE_W) ?
                               SAMPLE_BITS : vpcc_pkg::SAMPLE_W;
    localparam int STEP_BITS = $clog2(RELEASE_LIMIT + 1);
    localparam logic [STEP_BITS-1:0] STEP_LIMIT = STEP_BITS'(RELEASE_LIMIT);

    vpcc_pkg::mode_t       prev_mode_reg;
    vpcc_pkg::mode_t       prev_mode_next;
    logic [STEP_BITS-1:0]  step_reg;
    logic [STEP_BITS-1:0]  step_next;
    logic                  standby_reg;
    logic                  standby_next;
    logic                  pump_reg;
    logic                  pump_next;
    logic                  valve_reg;
    logic                  valve_next;

    vpcc_pkg::mode_t       mode;
    logic                  sensor;
    logic                  changed;
    logic [CMP_BITS-1:0]   vac;
    logic                  present;
    logic                  below_good;
    logic                  below_bad;
    logic [vpcc_pkg::STEP_CODE_W-1:0] step_code;

    // Sample decode and threshold compares.
    always_comb
    begin
        mode       = vpcc_pkg::mode_t'(item.pump_mode);
        sensor     = ~item.sensor_pin;
        changed    = (mode != prev_mode_reg);
        vac        = (mode == vpcc_pkg::MODE_DISABLED) ? '0 : item.vacuum_sample[CMP_BITS-1:0];
        present    = (mode != vpcc_pkg::MODE_DISABLED) &&
                     (vac >= cfg.presence_threshold[CMP_BITS-1:0]);
        below_good = vac < cfg.vacuum_good_level[CMP_BITS-1:0];
        below_bad  = vac < cfg.vacuum_bad_level[CMP_BITS-1:0];
    end

    // Next line levels and release step.
    always_comb
    begin
        prev_mode_next = mode;
        step_next      = step_reg;
        standby_next   = standby_reg;
        pump_next      = pump_reg;
        valve_next     = valve_reg;

        // A mode change drops everything on entry to disabled, else wakes the driver.
        if (changed)
        begin
            if (mode == vpcc_pkg::MODE_DISABLED)
            begin
                standby_next = 1'b0;
                pump_next    = 1'b0;
                valve_next   = 1'b0;
            end
            else
            begin
                standby_next = 1'b1;
            end
        end

        unique case (mode)
            vpcc_pkg::MODE_DISABLED:
            begin
            end
            vpcc_pkg::MODE_ON:
            begin
                valve_next = 1'b0;
                pump_next  = sensor && ((below_good && pump_next) || below_bad);
            end
            vpcc_pkg::MODE_FORCED:
            begin
                valve_next = 1'b0;
                pump_next  = 1'b1;
            end
            vpcc_pkg::MODE_OFF:
            begin
                // Step counter restarts on entry and saturates at the limit.
                if (changed)
                begin
                    step_next = '0;
                end
                else if (step_reg < STEP_LIMIT)
                begin
                    step_next = step_reg + 1'b1;
                end
            end
        endcase

        step_code = vpcc_pkg::STEP_CODE_W'(step_next);

        // Release sequence actions keyed on the current step.
        if (mode == vpcc_pkg::MODE_OFF)
        begin
            if (cfg.suction_on_release)
            begin
                if (step_code == vpcc_pkg::SUCTION_PUMP_START_STEP)
                    pump_next = 1'b1;
                else if (step_code == vpcc_pkg::SUCTION_VALVE_OPEN_STEP)
                    valve_next = 1'b1;
                else if (step_code == vpcc_pkg::SUCTION_PUMP_STOP_STEP)
                    pump_next = 1'b0;
                else if (step_code == vpcc_pkg::SUCTION_VALVE_CLOSE_STEP)
                    valve_next = 1'b0;
            end
            else
            begin
                if (step_code == vpcc_pkg::PLAIN_VALVE_OPEN_STEP)
                begin
                    pump_next  = 1'b0;
                    valve_next = 1'b1;
                end
                else if (step_code == vpcc_pkg::PLAIN_VALVE_CLOSE_STEP)
                begin
                    valve_next = 1'b0;
                end
            end
        end
    end

    // Channel state, updated once per transaction that moves to the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_mode_reg <= vpcc_pkg::MODE_DISABLED;
            step_reg      <= '0;
            standby_reg   <= 1'b0;
            pump_reg      <= 1'b0;
            valve_reg     <= 1'b0;
        end
        else if (advance)
        begin
            prev_mode_reg <= prev_mode_next;
            step_reg      <= step_next;
            standby_reg   <= standby_next;
            pump_reg      <= pump_next;
            valve_reg     <= valve_next;
        end
    end

    // Result of this tick.
    always_comb
    begin
        result.standby_release = standby_next;
        result.pump_drive      = pump_next;
        result.valve_open      = valve_next;
        result.part_present    = present;
        result.sensor_active   = sensor;
    end

endmodule

[sv/vacuum_pump_channel_control.sv]
// ----------------------------------------------------------------------------
// Vacuum pump channel control
// Top level: configuration registers, input register, channel logic and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction on in_valid/in_ready carries one control tick for
//   the channel (mode, raw sensor pin, vacuum sample). Each tick produces
//   exactly one output transaction on out_valid/out_ready with the driver
//   standby line, pump drive, valve drive and two status flags.
//   A tick passes through the input register and then the result register,
//   and out_valid rises as it enters the result register. Throughput is
//   one transaction per cycle while out_ready stays high; the channel
//   state updates as a tick moves from the input register into the result
//   register.
//   When the receiver stalls, the result register holds its transaction, the
//   input register fills, and in_ready drops until out_ready returns.
//   Reset clears both registers' valid flags, the configuration registers
//   and the channel state (mode disabled, all lines low, release step zero).
//   The configuration port (cfg_wr_en, cfg_index, cfg_wdata) writes one
//   register per cycle and is meant to be used while the channel is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vacuum_pump_channel_control #(
    parameter int SAMPLE_BITS   = vpcc_pkg::SAMPLE_BITS_DEFAULT,
    parameter int RELEASE_LIMIT = vpcc_pkg::RELEASE_LIMIT_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  vpcc_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output vpcc_pkg::out_item_t           out_data,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [vpcc_pkg::SAMPLE_W-1:0] cfg_wdata
);

    vpcc_pkg::cfg_t      cfg;
    vpcc_pkg::out_item_t result;

    logic                in_valid_reg;
    logic                in_valid_next;
    vpcc_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    vpcc_pkg::out_item_t out_item_reg;
    logic                advance;
    logic                in_take;

    vpcc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vpcc_channel_logic #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .RELEASE_LIMIT (RELEASE_LIMIT)
    ) u_channel_logic (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Handshake: a tick moves forward when the result register is free or drains.
    always_comb
    begin
        advance        = in_valid_reg && (!out_valid_reg || out_ready);
        in_ready       = !in_valid_reg || advance;
        in_take        = in_valid && in_ready;
        in_valid_next  = in_take || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !out_ready);
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

[sv/vpcc_checker.sv]
// ----------------------------------------------------------------------------
// Channel control checker
// Port-level assertions on the vacuum pump channel control, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vpcc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input vpcc_pkg::out_item_t out_data
);

    // A stalled output transaction stays put.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // With no result waiting the block always takes a new tick.
    `ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    // A part can only be reported while the driver is awake.
    `ASSERT_SAME(a_present_awake, clk, rst_n, out_valid && out_data.part_present, out_data.standby_release)

    // In standby the pump and valve are both off.
    `ASSERT_SAME(a_standby_quiet, clk, rst_n, out_valid && !out_data.standby_release, !out_data.pump_drive && !out_data.valve_open)

endmodule

bind vacuum_pump_channel_control vpcc_checker u_vpcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[tb/vpcc_tick_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vacuum pump channel tick checker
// Watches the tick, result and configuration ports of the channel control
// block. It keeps its own copy of the channel state and settings, predicts
// the driven lines and status flags for every accepted tick, and compares
// each accepted result with the oldest prediction field by field.
// ----------------------------------------------------------------------------

module vpcc_tick_checker #(
    parameter int SAMPLE_BITS   = vpcc_pkg::SAMPLE_BITS_DEFAULT,
    parameter int RELEASE_LIMIT = vpcc_pkg::RELEASE_LIMIT_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  vpcc_pkg::in_item_t            in_data,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  vpcc_pkg::out_item_t           out_data,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [vpcc_pkg::SAMPLE_W-1:0] cfg_wdata,
    output int                            mismatch_count,
    output int                            outputs_due
);

    import vpcc_pkg::*;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    // Settings and channel state as the block should hold them.
    cfg_t                   settings;
    mode_t                  last_mode;
    logic [STEP_CODE_W-1:0] release_step;
    logic                   standby_line;
    logic                   pump_line;
    logic                   valve_line;

    // Predicted results still waiting for their transaction.
    out_item_t pending_outputs[$];

    // Advance the channel by one tick and return the lines it drives.
    function automatic out_item_t advance_channel(in_item_t tick);
        mode_t         mode;
        logic          sensed;
        logic          changed;
        logic [SAMPLE_W-1:0] vac;
        out_item_t     lines;
        mode    = mode_t'(tick.pump_mode);
        sensed  = ~tick.sensor_pin;
        vac     = '0;
        lines   = '0;
        if (mode != MODE_DISABLED)
        begin
            vac = tick.vacuum_sample & SAMPLE_MASK;
            lines.part_present = (vac >= (settings.presence_threshold & SAMPLE_MASK));
        end

        changed   = (mode != last_mode);
        last_mode = mode;

        // A mode change either drops everything or wakes the driver.
        if (changed)
        begin
            if (mode == MODE_DISABLED)
            begin
                standby_line = 1'b0;
                pump_line    = 1'b0;
                valve_line   = 1'b0;
            end
            else
            begin
                standby_line = 1'b1;
            end
        end

        // Hysteresis in ON, unconditional run in forced ON.
        if (mode == MODE_ON)
        begin
            valve_line = 1'b0;
            if (sensed)
                pump_line = (vac < (settings.vacuum_good_level & SAMPLE_MASK) && pump_line)
                            || (vac < (settings.vacuum_bad_level & SAMPLE_MASK));
            else
                pump_line = 1'b0;
        end
        else if (mode == MODE_FORCED)
        begin
            valve_line = 1'b0;
            pump_line  = 1'b1;
        end

        // Timed release sequence while OFF.
        if (mode == MODE_OFF)
        begin
            if (changed)
                release_step = '0;
            else if (release_step < RELEASE_LIMIT)
                release_step = release_step + 1'b1;

            if (settings.suction_on_release)
            begin
                if (release_step == SUCTION_PUMP_START_STEP)
                    pump_line = 1'b1;
                else if (release_step == SUCTION_VALVE_OPEN_STEP)
                    valve_line = 1'b1;
                else if (release_step == SUCTION_PUMP_STOP_STEP)
                    pump_line = 1'b0;
                else if (release_step == SUCTION_VALVE_CLOSE_STEP)
                    valve_line = 1'b0;
            end
            else
            begin
                if (release_step == PLAIN_VALVE_OPEN_STEP)
                begin
                    pump_line  = 1'b0;
                    valve_line = 1'b1;
                end
                else if (release_step == PLAIN_VALVE_CLOSE_STEP)
                begin
                    valve_line = 1'b0;
                end
            end
        end

        lines.standby_release = standby_line;
        lines.pump_drive      = pump_line;
        lines.valve_open      = valve_line;
        lines.sensor_active   = sensed;
        return lines;
    endfunction

    task automatic check_field(string name, logic want, logic got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
        end
    endtask

    // Track settings, predict on every tick and compare every result.
    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            settings       = '0;
            last_mode      = MODE_DISABLED;
            release_step   = '0;
            standby_line   = 1'b0;
            pump_line      = 1'b0;
            valve_line     = 1'b0;
            mismatch_count = 0;
            pending_outputs.delete();
            outputs_due   <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_PRESENCE_THRESHOLD: settings.presence_threshold = cfg_wdata;
                    CFG_VACUUM_GOOD_LEVEL:  settings.vacuum_good_level  = cfg_wdata;
                    CFG_VACUUM_BAD_LEVEL:   settings.vacuum_bad_level   = cfg_wdata;
                    CFG_SUCTION_ON_RELEASE: settings.suction_on_release = cfg_wdata[0];
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                pending_outputs.push_back(advance_channel(in_data));

            if (out_valid && out_ready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result transaction, expected none actual %b",
                             $time, out_data);
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    check_field("standby_release", want.standby_release,
                                out_data.standby_release);
                    check_field("pump_drive", want.pump_drive, out_data.pump_drive);
                    check_field("valve_open", want.valve_open, out_data.valve_open);
                    check_field("part_present", want.part_present, out_data.part_present);
                    check_field("sensor_active", want.sensor_active, out_data.sensor_active);
                end
            end

            outputs_due <= pending_outputs.size();
        end
    end

endmodule

[tb/vacuum_pump_channel_control_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vacuum pump channel control testbench
// Drives control ticks into the channel block: a directed opening over the
// hysteresis, forced run, suction release and disable cases, then random
// mode runs with vacuum samples clustered around the thresholds, under
// several settings and idling patterns. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module vacuum_pump_channel_control_tb;

    import vpcc_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int SETTLE_TICKS = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int BLOCK_TICKS  = 120;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    in_item_t            in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_item_t           out_data;
    logic                cfg_wr_en = 1'b0;
    logic [1:0]          cfg_index = '0;
    logic [SAMPLE_W-1:0] cfg_wdata = '0;

    int   mismatch_count;
    int   outputs_due;
    int   tx_idle_pct  = 0;
    int   rx_idle_pct  = 0;
    int   hold_cycles  = 0;
    bit   hold_request = 1'b0;
    int   cycles       = 0;
    cfg_t active_cfg   = '0;

    vacuum_pump_channel_control dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    vpcc_tick_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .outputs_due    (outputs_due)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Run limit.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random back-pressure, or a long hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    function automatic in_item_t tick(mode_t mode, logic pin, logic [SAMPLE_W-1:0] vac);
        in_item_t t;
        t.pump_mode     = mode;
        t.sensor_pin    = pin;
        t.vacuum_sample = vac;
        return t;
    endfunction

    // Offer one tick, possibly after an idle gap, and wait for acceptance.
    task automatic send_tick(in_item_t t);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outputs_due != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Write all four registers while the channel is idle.
    task automatic apply_settings(cfg_t s);
        wait_idle();
        active_cfg = s;
        for (int i = 0; i < 4; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= cfg_index_t'(i);
            case (cfg_index_t'(i))
                CFG_PRESENCE_THRESHOLD: cfg_wdata <= s.presence_threshold;
                CFG_VACUUM_GOOD_LEVEL:  cfg_wdata <= s.vacuum_good_level;
                CFG_VACUUM_BAD_LEVEL:   cfg_wdata <= s.vacuum_bad_level;
                default:                cfg_wdata <= SAMPLE_W'(s.suction_on_release);
            endcase
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Settings for one random block; the first two are the extremes.
    function automatic cfg_t settings_for(int k);
        cfg_t s;
        s.presence_threshold = SAMPLE_W'($urandom_range(0, 4095));
        s.vacuum_good_level  = SAMPLE_W'($urandom_range(0, 4095));
        s.vacuum_bad_level   = SAMPLE_W'($urandom_range(0, 4095));
        s.suction_on_release = 1'($urandom_range(0, 1));
        case (k)
            0: s = '{12'hFFF, 12'hFFF, 12'hFFF, 1'b1};
            1: s = '{12'h000, 12'h000, 12'h000, 1'b0};
            2:
            begin
                s.vacuum_bad_level  = SAMPLE_W'($urandom_range(256, 2047));
                s.vacuum_good_level = SAMPLE_W'(s.vacuum_bad_level + $urandom_range(64, 1024));
            end
            default: ;
        endcase
        return s;
    endfunction

    // Vacuum samples: mostly near a threshold, some fixed extremes and patterns, some anywhere.
    function automatic logic [SAMPLE_W-1:0] pick_vacuum();
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            return SAMPLE_W'($urandom_range(0, 4095));
        if (sel < 40)
        begin
            case ($urandom_range(0, 3))
                0:       return 12'h000;
                1:       return 12'hFFF;
                2:       return 12'hAAA;
                default: return 12'h555;
            endcase
        end
        case ($urandom_range(0, 2))
            0:       v = int'(active_cfg.presence_threshold);
            1:       v = int'(active_cfg.vacuum_good_level);
            default: v = int'(active_cfg.vacuum_bad_level);
        endcase
        v = v + int'($urandom_range(0, 16)) - 8;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return SAMPLE_W'(v);
    endfunction

    // Runs of one commanded mode; OFF runs can be long enough to reach the
    // late valve step and the counter saturation.
    task automatic run_block(int count);
        int    sent;
        int    run_len;
        mode_t mode;
        logic  pin;
        sent = 0;
        while (sent < count)
        begin
            mode = mode_t'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0)
                run_len = 1;
            else if (mode == MODE_OFF)
                run_len = $urandom_range(3, 26);
            else
                run_len = $urandom_range(1, 12);
            for (int i = 0; i < run_len && sent < count; i++)
            begin
                if (mode == MODE_ON)
                    pin = ($urandom_range(0, 4) == 0);
                else
                    pin = 1'($urandom_range(0, 1));
                send_tick(tick(mode, pin, pick_vacuum()));
                sent++;
            end
        end
    endtask

    task automatic run_phase(int tx_pct, int rx_pct, int first_k, bit with_hold);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int b = 0; b < 3; b++)
        begin
            apply_settings(settings_for(first_k + b));
            // Long receiver hold-off while ticks keep coming.
            if (with_hold && b == 0)
            begin
                hold_cycles  = 50;
                hold_request = 1'b1;
            end
            run_block(BLOCK_TICKS);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: hysteresis, sensor loss, forced run, suction release,
        // entry into disabled and leaving OFF mid-sequence.
        apply_settings('{12'h800, 12'hC00, 12'h400, 1'b1});
        send_tick(tick(MODE_ON, 1'b0, 12'h000));
        send_tick(tick(MODE_ON, 1'b0, 12'h7FF));
        send_tick(tick(MODE_ON, 1'b0, 12'h800));
        send_tick(tick(MODE_ON, 1'b0, 12'hC00));
        send_tick(tick(MODE_ON, 1'b0, 12'h7FF));
        send_tick(tick(MODE_ON, 1'b0, 12'h3FF));
        send_tick(tick(MODE_ON, 1'b1, 12'hFFF));
        send_tick(tick(MODE_FORCED, 1'b1, 12'hFFF));
        repeat (7) send_tick(tick(MODE_OFF, 1'b0, 12'hAAA));
        send_tick(tick(MODE_DISABLED, 1'b0, 12'hFFF));
        send_tick(tick(MODE_DISABLED, 1'b1, 12'h000));
        send_tick(tick(MODE_FORCED, 1'b0, 12'h555));
        send_tick(tick(MODE_DISABLED, 1'b1, 12'hFFF));
        send_tick(tick(MODE_OFF, 1'b1, 12'h800));
        send_tick(tick(MODE_OFF, 1'b1, 12'h7FF));
        send_tick(tick(MODE_ON, 1'b0, 12'h000));
        send_tick(tick(MODE_OFF, 1'b0, 12'hFFF));

        run_phase(24, 60, 0, 1'b0);
        run_phase(60, 24, 3, 1'b0);
        run_phase(0, 0, 6, 1'b1);

        wait_idle();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
